>>> hw/rtl/dtrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtrc_pkg: shared types and constants
// Status codes, record layout and the item command passed to the cell row.
// ----------------------------------------------------------------------------
package dtrc_pkg;

    localparam int CACHE_ENTRIES_DEF = 16;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_INVALID_ARG = 3'd1;
    localparam logic [2:0] ST_NOT_INIT    = 3'd2;
    localparam logic [2:0] ST_NO_MEMORY   = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND   = 3'd4;

    localparam logic [2:0] ATTR_CURRENT = 3'd0;
    localparam logic [2:0] ATTR_MIN     = 3'd1;
    localparam logic [2:0] ATTR_MAX     = 3'd2;
    localparam logic [2:0] ATTR_ALARM   = 3'd3;
    localparam logic [2:0] ATTR_LOW     = 3'd4;
    localparam logic [2:0] ATTR_HIGH    = 3'd5;

    localparam logic [0:0] REG_ENABLED = 1'd0;
    localparam logic [0:0] REG_MARKER  = 1'd1;

    // one cached record
    typedef struct packed {
        logic [15:0] addr;
        logic [15:0] cur;
        logic [15:0] mn;
        logic [15:0] mx;
        logic [15:0] alarm;
        logic [15:0] lo;
        logic [15:0] hi;
        logic        valid;
        logic [31:0] stamp;
    } rec_t;

    // update command applied by one cell
    typedef struct packed {
        logic        wr;      // claim slot with new address
        logic        clr;     // evicted: clear data
        logic        store;   // attribute write allowed
        logic        stamp;   // restamp
        logic [2:0]  attr;
        logic [15:0] addr;
        logic [15:0] val;
        logic [31:0] now;
    } upd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY
    } state_t;

endpackage

>>> hw/rtl/device_temp_report_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// device_temp_report_cache: per-device temperature record cache
// Fully associative table of records kept in a rotating row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the item fields and raise start while busy is low; the item is
//   transferred at that edge. One result comes out per item, marked by
//   done for exactly one cycle; the receiver cannot stall it.
//   Items that need no table access (zero-length reports, disabled, queries
//   without cluster) finish without touching the ring. Queries, and reports
//   that find nothing to evict, rotate the ring of CACHE_ENTRIES cells once.
//   Other reports rotate once to find the hit, the first empty slot and the
//   oldest stamp, then once more applying the update in the last cell, to
//   the record leaving the head. The ring rotates one cell per cycle. busy
//   stays high through the done cycle, so the next item can be taken no
//   earlier than the cycle after the result.
//   Reset clears every record (address zero, all fields zero), enabled,
//   and sets invalid_marker to 0x8000. Registers must be written over the
//   APB port only while the block is idle (enabled at 0x0, invalid_marker
//   at 0x4); the block itself does not enforce this.
// ----------------------------------------------------------------------------
module device_temp_report_cache
#(
    parameter int CACHE_ENTRIES = dtrc_pkg::CACHE_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic        mode,
    input  logic [15:0] device_addr,
    input  logic [2:0]  attribute,
    input  logic [15:0] attr_value,
    input  logic [7:0]  value_length,
    input  logic [31:0] timestamp,
    input  logic        supports_cluster,
    output logic [2:0]  status,
    output logic        hit,
    output logic signed [15:0] current_temp,
    output logic signed [15:0] min_temp,
    output logic signed [15:0] max_temp,
    output logic [15:0] over_alarm,
    output logic signed [15:0] low_limit,
    output logic signed [15:0] high_limit,
    output logic        record_valid,
    output logic [31:0] update_time
);

    localparam int IW = $clog2(CACHE_ENTRIES);
    localparam int CW = $clog2(CACHE_ENTRIES + 1);
    localparam logic [CW-1:0] LAST = CW'(CACHE_ENTRIES - 1);

    // configuration registers
    logic        enabled_reg;
    logic [15:0] marker_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            marker_reg  <= 16'h8000;
        end
        else if (wr_en)
        begin
            if (paddr[2] == dtrc_pkg::REG_MARKER && paddr[1:0] == 2'b00)
            begin
                marker_reg <= pwdata[15:0];
            end
            else if (paddr[2] == dtrc_pkg::REG_ENABLED && paddr[1:0] == 2'b00)
            begin
                enabled_reg <= pwdata[0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == {dtrc_pkg::REG_ENABLED, 2'b00})
        begin
            prdata = {31'd0, enabled_reg};
        end
        else if (paddr == {dtrc_pkg::REG_MARKER, 2'b00})
        begin
            prdata = {16'd0, marker_reg};
        end
    end

    // item latch
    logic        mode_reg;
    logic [15:0] addr_reg;
    logic [2:0]  attr_reg;
    logic [15:0] val_reg;
    logic [7:0]  len_reg;
    logic [31:0] now_reg;
    logic        clus_reg;

    // ring of cells
    dtrc_pkg::rec_t ring [CACHE_ENTRIES];
    logic           shift;
    logic           apply;
    dtrc_pkg::upd_t upd;

    for (genvar g = 0; g < CACHE_ENTRIES; g++)
    begin : g_cell
        dtrc_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .shift   (shift),
            .apply   (apply && (g == CACHE_ENTRIES - 1)),
            .upd     (upd),
            .rec_in  (ring[(g + 1) % CACHE_ENTRIES]),
            .rec_out (ring[g])
        );
    end

    // ring[0] is the slot currently at the head; it moves to the last cell
    dtrc_pkg::rec_t head;
    assign head = ring[0];

    // controller state
    dtrc_pkg::state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          fnd_reg, fnd_next;      // match or empty found
    logic [IW-1:0] fidx_reg, fidx_next;
    logic          fmatch_reg, fmatch_next; // found by address match
    logic          vic_reg, vic_next;
    logic [IW-1:0] vidx_reg, vidx_next;
    logic [31:0]   best_reg, best_next;
    logic          qhit_reg, qhit_next;
    dtrc_pkg::rec_t qrec_reg, qrec_next;
    logic          done_reg, done_next;
    logic [2:0]    st_reg, st_next;
    logic          quick;
    logic [2:0]    quick_st;
    logic          first_item;   // cycle after transfer
    logic          first_reg;

    assign busy = (state_reg != dtrc_pkg::S_IDLE) || done_reg || first_reg;

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            mode_reg <= mode;
            addr_reg <= device_addr;
            attr_reg <= attribute;
            val_reg  <= attr_value;
            len_reg  <= value_length;
            now_reg  <= timestamp;
            clus_reg <= supports_cluster;
        end
    end

    // early exits that touch no slot
    always_comb
    begin
        quick    = 1'b1;
        quick_st = dtrc_pkg::ST_OK;
        if (!mode_reg && len_reg == 8'd0)
        begin
            quick_st = dtrc_pkg::ST_INVALID_ARG;
        end
        else if (!enabled_reg)
        begin
            quick_st = dtrc_pkg::ST_NOT_INIT;
        end
        else if (mode_reg && !clus_reg)
        begin
            quick_st = dtrc_pkg::ST_NOT_FOUND;
        end
        else
        begin
            quick = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b0;
        end
        else
        begin
            first_reg <= start && !busy;
        end
    end
    assign first_item = first_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dtrc_pkg::S_IDLE:
                if (first_item && !quick)
                begin
                    state_next = dtrc_pkg::S_SCAN;
                end
            dtrc_pkg::S_SCAN:
                if (cnt_reg == LAST)
                begin
                    state_next = (mode_reg || (!fnd_reg && !vic_reg &&
                        !(head.addr == addr_reg || head.addr == 16'd0) &&
                        !(head.stamp < best_reg)))
                        ? dtrc_pkg::S_IDLE : dtrc_pkg::S_APPLY;
                end
            dtrc_pkg::S_APPLY:
                if (cnt_reg == LAST)
                begin
                    state_next = dtrc_pkg::S_IDLE;
                end
            default: state_next = dtrc_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cnt_next    = cnt_reg;
        fnd_next    = fnd_reg;
        fidx_next   = fidx_reg;
        fmatch_next = fmatch_reg;
        vic_next    = vic_reg;
        vidx_next   = vidx_reg;
        best_next   = best_reg;
        qhit_next   = qhit_reg;
        qrec_next   = qrec_reg;
        done_next   = 1'b0;
        st_next     = st_reg;
        shift       = 1'b0;
        apply       = 1'b0;
        upd         = '0;
        upd.attr    = attr_reg;
        upd.addr    = addr_reg;
        upd.val     = val_reg;
        upd.now     = now_reg;
        case (state_reg)
            dtrc_pkg::S_IDLE:
            begin
                cnt_next   = '0;
                fnd_next   = 1'b0;
                fmatch_next = 1'b0;
                vic_next   = 1'b0;
                best_next  = '1;
                qhit_next  = 1'b0;
                if (first_item)
                begin
                    st_next = quick_st;
                    done_next = quick;
                end
            end
            dtrc_pkg::S_SCAN:
            begin
                shift = 1'b1;
                if (!fnd_reg)
                begin
                    if (head.addr == addr_reg)
                    begin
                        fnd_next    = 1'b1;
                        fmatch_next = 1'b1;
                        fidx_next   = cnt_reg[IW-1:0];
                        qhit_next   = head.valid;
                        qrec_next   = head;
                    end
                    else if (head.addr == 16'd0 && !mode_reg)
                    begin
                        // a report claims the first empty slot; a query skips it
                        fnd_next  = 1'b1;
                        fidx_next = cnt_reg[IW-1:0];
                    end
                    else if (head.stamp < best_reg)
                    begin
                        vic_next  = 1'b1;
                        vidx_next = cnt_reg[IW-1:0];
                        best_next = head.stamp;
                    end
                end
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == LAST)
                begin
                    cnt_next = '0;
                    if (mode_reg)
                    begin
                        st_next   = dtrc_pkg::ST_OK;
                        done_next = 1'b1;
                    end
                    else if (!fnd_next && !vic_next)
                    begin
                        st_next   = dtrc_pkg::ST_NO_MEMORY;
                        done_next = 1'b1;
                    end
                end
            end
            dtrc_pkg::S_APPLY:
            begin
                shift = 1'b1;
                if (fnd_reg ? (cnt_reg[IW-1:0] == fidx_reg)
                            : (cnt_reg[IW-1:0] == vidx_reg))
                begin
                    apply     = 1'b1;
                    upd.wr    = !fmatch_reg;
                    upd.clr   = !fnd_reg;
                    upd.store = len_reg >= 8'd2;
                    upd.stamp = attr_reg <= dtrc_pkg::ATTR_HIGH;
                end
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == LAST)
                begin
                    cnt_next  = '0;
                    st_next   = dtrc_pkg::ST_OK;
                    done_next = 1'b1;
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= dtrc_pkg::S_IDLE;
            cnt_reg    <= '0;
            fnd_reg    <= 1'b0;
            fmatch_reg <= 1'b0;
            vic_reg    <= 1'b0;
            qhit_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            fnd_reg    <= fnd_next;
            fmatch_reg <= fmatch_next;
            vic_reg    <= vic_next;
            qhit_reg   <= qhit_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fidx_reg <= fidx_next;
        vidx_reg <= vidx_next;
        best_reg <= best_next;
        qrec_reg <= qrec_next;
        st_reg   <= st_next;
    end

    // result ports
    logic q_ok;
    assign q_ok = mode_reg && st_reg == dtrc_pkg::ST_OK;

    assign done           = done_reg;
    assign status         = st_reg;
    assign hit            = q_ok && qhit_reg;
    assign record_valid   = q_ok && qhit_reg;
    assign current_temp   = !q_ok ? 16'sd0 : qhit_reg ? qrec_reg.cur : marker_reg;
    assign min_temp       = !q_ok ? 16'sd0 : qhit_reg ? qrec_reg.mn  : marker_reg;
    assign max_temp       = !q_ok ? 16'sd0 : qhit_reg ? qrec_reg.mx  : marker_reg;
    assign over_alarm     = (q_ok && qhit_reg) ? qrec_reg.alarm : 16'd0;
    assign low_limit      = (q_ok && qhit_reg) ? qrec_reg.lo    : 16'sd0;
    assign high_limit     = (q_ok && qhit_reg) ? qrec_reg.hi    : 16'sd0;
    assign update_time    = (q_ok && qhit_reg) ? qrec_reg.stamp : 32'd0;

    // checks
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for two cycles");
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result while not busy");
    a_apply_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        apply |-> state_reg == dtrc_pkg::S_APPLY)
        else $error("update outside apply pass");
    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> status == dtrc_pkg::ST_OK)
        else $error("hit without ok result");

endmodule

>>> hw/rtl/dtrc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtrc_cell: one slot of the record ring
// Holds a record, passes it to the neighbor while rotating, and applies
// an update to the record leaving position zero.
// ----------------------------------------------------------------------------
module dtrc_cell
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          shift,
    input  logic          apply,
    input  dtrc_pkg::upd_t upd,
    input  dtrc_pkg::rec_t rec_in,
    output dtrc_pkg::rec_t rec_out
);

    dtrc_pkg::rec_t rec_reg;
    dtrc_pkg::rec_t rec_next;

    // update of the incoming record when this is the last cell, fed by the head
    always_comb
    begin
        rec_next = rec_in;
        if (apply)
        begin
            if (upd.wr)
            begin
                rec_next.addr = upd.addr;
            end
            if (upd.clr)
            begin
                rec_next.cur   = '0;
                rec_next.mn    = '0;
                rec_next.mx    = '0;
                rec_next.alarm = '0;
                rec_next.lo    = '0;
                rec_next.hi    = '0;
                rec_next.valid = 1'b0;
                rec_next.stamp = '0;
            end
            if (upd.store)
            begin
                case (upd.attr)
                    dtrc_pkg::ATTR_CURRENT:
                    begin
                        rec_next.cur   = upd.val;
                        rec_next.valid = 1'b1;
                    end
                    dtrc_pkg::ATTR_MIN:   rec_next.mn    = upd.val;
                    dtrc_pkg::ATTR_MAX:   rec_next.mx    = upd.val;
                    dtrc_pkg::ATTR_ALARM: rec_next.alarm = upd.val;
                    dtrc_pkg::ATTR_LOW:   rec_next.lo    = upd.val;
                    dtrc_pkg::ATTR_HIGH:  rec_next.hi    = upd.val;
                    default:              rec_next.cur   = rec_next.cur;
                endcase
            end
            if (upd.stamp)
            begin
                rec_next.stamp = upd.now;
            end
        end
    end

    // record register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= '0;
        end
        else if (shift)
        begin
            rec_reg <= rec_next;
        end
    end

    assign rec_out = rec_reg;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the device temperature report cache
// Drives report and query items with random gaps, predicts every result with
// an internal table model and compares each field of each done transfer.
// ----------------------------------------------------------------------------
module tb;

    localparam int ENTRIES = dtrc_pkg::CACHE_ENTRIES_DEF;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]  status;
        logic        hit;
        logic [15:0] cur;
        logic [15:0] mn;
        logic [15:0] mx;
        logic [15:0] alarm;
        logic [15:0] lo;
        logic [15:0] hi;
        logic        valid;
        logic [31:0] stamp;
    } answer_t;

    // table model and queue of pending answers
    class temp_cache_board;
        logic           enabled;
        logic [15:0]    marker;
        dtrc_pkg::rec_t slots [ENTRIES];
        answer_t        pending [$];
        int             errors;

        function new();
            enabled = 1'b0;
            marker = 16'h8000;
            errors = 0;
            foreach (slots[i]) slots[i] = '0;
        endfunction

        function int claim(logic [15:0] addr);
            int victim;
            logic [31:0] best;
            victim = -1;
            best = 32'hFFFF_FFFF;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (slots[i].addr == addr) return i;
                if (slots[i].addr == 16'd0)
                begin
                    slots[i].addr = addr;
                    return i;
                end
                if (slots[i].stamp < best)
                begin
                    best = slots[i].stamp;
                    victim = i;
                end
            end
            if (victim >= 0)
            begin
                slots[victim] = '0;
                slots[victim].addr = addr;
            end
            return victim;
        endfunction

        // note an accepted item and queue its answer
        function void note_item(logic md, logic [15:0] addr, logic [2:0] attr,
                                logic [15:0] val, logic [7:0] len,
                                logic [31:0] now, logic cl);
            answer_t a;
            int s;
            int j;
            logic wr;
            a = '0;
            if (md == 1'b0)
            begin
                if (len == 8'd0) a.status = dtrc_pkg::ST_INVALID_ARG;
                else if (!enabled) a.status = dtrc_pkg::ST_NOT_INIT;
                else
                begin
                    s = claim(addr);
                    if (s < 0) a.status = dtrc_pkg::ST_NO_MEMORY;
                    else
                    begin
                        a.status = dtrc_pkg::ST_OK;
                        wr = (len >= 8'd2);
                        if (attr <= dtrc_pkg::ATTR_HIGH)
                        begin
                            if (wr)
                            begin
                                case (attr)
                                    dtrc_pkg::ATTR_CURRENT:
                                    begin
                                        slots[s].cur = val;
                                        slots[s].valid = 1'b1;
                                    end
                                    dtrc_pkg::ATTR_MIN:   slots[s].mn = val;
                                    dtrc_pkg::ATTR_MAX:   slots[s].mx = val;
                                    dtrc_pkg::ATTR_ALARM: slots[s].alarm = val;
                                    dtrc_pkg::ATTR_LOW:   slots[s].lo = val;
                                    default:              slots[s].hi = val;
                                endcase
                            end
                            slots[s].stamp = now;
                        end
                    end
                end
            end
            else if (!enabled) a.status = dtrc_pkg::ST_NOT_INIT;
            else if (!cl) a.status = dtrc_pkg::ST_NOT_FOUND;
            else
            begin
                a.status = dtrc_pkg::ST_OK;
                for (j = 0; j < ENTRIES; j++)
                    if (slots[j].addr == addr) break;
                if (j < ENTRIES && slots[j].valid)
                begin
                    a.hit = 1'b1;
                    a.cur = slots[j].cur;
                    a.mn = slots[j].mn;
                    a.mx = slots[j].mx;
                    a.alarm = slots[j].alarm;
                    a.lo = slots[j].lo;
                    a.hi = slots[j].hi;
                    a.valid = 1'b1;
                    a.stamp = slots[j].stamp;
                end
                else
                begin
                    a.cur = marker;
                    a.mn = marker;
                    a.mx = marker;
                end
            end
            pending.push_back(a);
        endfunction

        // compare one result transfer with the oldest answer
        function void check_answer(answer_t got);
            answer_t w;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (w.status !== got.status) report("status", 32'(w.status), 32'(got.status));
            if (w.hit !== got.hit) report("hit", 32'(w.hit), 32'(got.hit));
            if (w.cur !== got.cur) report("current_temp", 32'(w.cur), 32'(got.cur));
            if (w.mn !== got.mn) report("min_temp", 32'(w.mn), 32'(got.mn));
            if (w.mx !== got.mx) report("max_temp", 32'(w.mx), 32'(got.mx));
            if (w.alarm !== got.alarm) report("over_alarm", 32'(w.alarm), 32'(got.alarm));
            if (w.lo !== got.lo) report("low_limit", 32'(w.lo), 32'(got.lo));
            if (w.hi !== got.hi) report("high_limit", 32'(w.hi), 32'(got.hi));
            if (w.valid !== got.valid) report("record_valid", 32'(w.valid), 32'(got.valid));
            if (w.stamp !== got.stamp) report("update_time", w.stamp, got.stamp);
        endfunction

        function void report(string f, logic [31:0] w, logic [31:0] g);
            $display("%0t: %s mismatch expected %h actual %h", $realtime, f, w, g);
            errors++;
        endfunction
    endclass

    logic        clk, rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic        start, busy, done;
    logic        mode;
    logic [15:0] device_addr;
    logic [2:0]  attribute;
    logic [15:0] attr_value;
    logic [7:0]  value_length;
    logic [31:0] timestamp;
    logic        supports_cluster;
    logic [2:0]  status;
    logic        hit;
    logic signed [15:0] current_temp, min_temp, max_temp;
    logic [15:0] over_alarm;
    logic signed [15:0] low_limit, high_limit;
    logic        record_valid;
    logic [31:0] update_time;

    temp_cache_board board;
    int idle_cycles = 0;
    logic [31:0] clock_now;

    device_temp_report_cache u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // result transfers and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                board.check_answer({status, hit, current_temp, min_temp, max_temp,
                                    over_alarm, low_limit, high_limit,
                                    record_valid, update_time});
            if (done || (start && !busy) || (psel && penable)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == {dtrc_pkg::REG_ENABLED, 2'b00}) board.enabled = data[0];
        else board.marker = data[15:0];
    endtask

    // wait until every answer has come back and the block has settled
    task automatic drain();
        while (board.pending.size() != 0 || busy) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic send_item(logic md, logic [15:0] addr, logic [2:0] attr,
                             logic [15:0] val, logic [7:0] len, logic cl);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        repeat (gap) @(negedge clk);
        while (busy) @(negedge clk);
        clock_now = ($urandom_range(0, 40) == 0) ? 32'hFFFF_FFFF
                  : clock_now + $urandom_range(0, 3);
        mode <= md; device_addr <= addr; attribute <= attr; attr_value <= val;
        value_length <= len; timestamp <= clock_now; supports_cluster <= cl;
        start <= 1'b1;
        @(posedge clk);
        board.note_item(md, addr, attr, val, len, clock_now, cl);
        @(negedge clk);
        start <= 1'b0;
        mode <= 1'($urandom); device_addr <= 16'($urandom); attr_value <= 16'($urandom);
    endtask

    // random item, addresses mostly drawn from 1 to pool, a pool smaller or larger than the table
    task automatic random_item(int pool);
        logic [15:0] addr;
        int r;
        r = $urandom_range(0, 99);
        addr = (r < 85) ? 16'($urandom_range(1, pool)) : 16'($urandom);
        if (r == 99) addr = 16'd0;
        send_item($urandom_range(0, 99) < 40, addr, 3'($urandom_range(0, 7)),
                  16'($urandom),
                  ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 1)) : 8'($urandom),
                  $urandom_range(0, 9) != 0);
    endtask

    initial
    begin
        board = new();
        clock_now = 32'd100;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        start = 1'b0; mode = 1'b0; device_addr = '0; attribute = '0;
        attr_value = '0; value_length = '0; timestamp = '0; supports_cluster = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // disabled block, zero length before the enabled check
        send_item(1'b0, 16'h0001, dtrc_pkg::ATTR_CURRENT, 16'h1234, 8'd2, 1'b1);
        send_item(1'b0, 16'h0001, dtrc_pkg::ATTR_CURRENT, 16'h1234, 8'd0, 1'b1);
        send_item(1'b1, 16'h0001, dtrc_pkg::ATTR_CURRENT, 16'h0, 8'd0, 1'b1);
        drain();
        write_reg({dtrc_pkg::REG_ENABLED, 2'b00}, 32'd1);

        // every attribute, short value, unknown code, misses and address zero
        for (int a = 0; a < 8; a++)
            send_item(1'b0, 16'hFFFF, 3'(a), 16'h8000 + 16'(a), 8'd2, 1'b1);
        send_item(1'b0, 16'h0002, dtrc_pkg::ATTR_MIN, 16'h7FFF, 8'd1, 1'b1);
        send_item(1'b1, 16'hFFFF, dtrc_pkg::ATTR_CURRENT, 16'h0, 8'd0, 1'b1);
        send_item(1'b1, 16'h0002, dtrc_pkg::ATTR_CURRENT, 16'h0, 8'd0, 1'b1);
        send_item(1'b1, 16'hFFFF, dtrc_pkg::ATTR_CURRENT, 16'h0, 8'd0, 1'b0);
        send_item(1'b0, 16'h0000, dtrc_pkg::ATTR_CURRENT, 16'hFFFF, 8'd255, 1'b1);
        send_item(1'b1, 16'h0000, dtrc_pkg::ATTR_CURRENT, 16'h0, 8'd0, 1'b1);
        send_item(1'b0, 16'h0003, dtrc_pkg::ATTR_HIGH, 16'h0001, 8'd2, 1'b1);
        drain();
        write_reg({dtrc_pkg::REG_MARKER, 2'b00}, 32'h0000_7FFF);

        // random phases under several register settings
        for (int ph = 0; ph < 6; ph++)
        begin
            for (int n = 0; n < 120; n++) random_item((ph % 2) ? 12 : 40);
            drain();
            case (ph)
                0: write_reg({dtrc_pkg::REG_MARKER, 2'b00}, 32'h0000_0000);
                1: write_reg({dtrc_pkg::REG_ENABLED, 2'b00}, 32'd0);
                2: write_reg({dtrc_pkg::REG_ENABLED, 2'b00}, 32'd1);
                3: write_reg({dtrc_pkg::REG_MARKER, 2'b00}, 32'($urandom));
                default: write_reg({dtrc_pkg::REG_MARKER, 2'b00}, 32'h0000_8000);
            endcase
        end

        // fill the table with all-ones stamps to reach no_memory
        clock_now = 32'hFFFF_FFFF;
        for (int n = 0; n < 40; n++)
        begin
            while (busy) @(negedge clk);
            mode <= 1'b0; device_addr <= 16'(16'h4000 + n);
            attribute <= dtrc_pkg::ATTR_CURRENT;
            attr_value <= 16'($urandom); value_length <= 8'd2;
            timestamp <= 32'hFFFF_FFFF;
            supports_cluster <= 1'b1; start <= 1'b1;
            @(posedge clk);
            board.note_item(1'b0, 16'(16'h4000 + n), dtrc_pkg::ATTR_CURRENT, attr_value,
                            8'd2, 32'hFFFF_FFFF, 1'b1);
            @(negedge clk);
            start <= 1'b0;
        end
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

>>> files.f
hw/rtl/dtrc_pkg.sv
hw/rtl/dtrc_cell.sv
hw/rtl/device_temp_report_cache.sv
tb/tb.sv
